[src/bapyr_pkg.sv]
// Shared constants and types for the box-average image pyramid.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package bapyr_pkg;

	// default values of the top level parameters
	localparam int DEF_LEVELS    = 4;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_FRAC_BITS = 6;

	// input pixel and stream widths
	localparam int PIX_W        = 8;
	localparam int TDATA_IN_W   = 8;
	localparam int TDATA_OUT_W  = 40;

	// fixed limits of the height side
	localparam int MAX_HEIGHT = 4096;
	localparam int HGT_W      = 13;
	localparam int ROW_W      = 13;

	// configuration port
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int WREG_W    = 11;
	localparam int HREG_W    = 13;
	localparam int NREG_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT  = 2'd2;

	localparam logic [WREG_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
	localparam logic [HREG_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
	localparam logic [NREG_W-1:0] RST_LEVEL_COUNT  = 3'd4;

	// output field widths
	localparam int LEV_OUT_W = 2;
	localparam int COL_OUT_W = 10;
	localparam int ROW_OUT_W = 12;
	localparam int PIX_OUT_W = 14;

	// one result slot of a run
	typedef struct packed {
		logic                 vld;
		logic [PIX_OUT_W-1:0] pix;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] col;
		logic [LEV_OUT_W-1:0] lev;
	} result_t;

	// control that travels with an item from cell to cell
	typedef struct packed {
		logic valid;
		logic go;
		logic frame_end;
	} link_t;

endpackage

[src/box_average_image_pyramid.sv]
// Top level of the streaming 2x2 box-average image pyramid.
// Depends on bapyr_pkg, bapyr_cell and bapyr_serial.
`timescale 1ns / 1ps
//
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// s_*       | in        | s_tvalid/s_tready  | tdata[7:0] pixel_value
// m_*       | out       | m_tvalid/m_tready  | tdata: level_index, column, row,
//           |           |                    | level_pixel; tlast: last_of_run
// cfg_*     | in        | cfg_we             | cfg_index, cfg_data
//
// An item passes through LEVELS cells, each of which registers it, then lands in the
// output stage register, from which its results go out on m_*. A new item is accepted
// every cycle as long as the output stage keeps up: a run of k results holds the
// output stage until all k are taken, and the next item enters only as the last leaves.
// Reset loads width 1024, height 768 and 4 levels and clears every position
// counter; line memories are not cleared, since a frame always writes an entry
// before it reads it. Ready ripples back from m_tready through the cells, so empty
// cells fill up while the output stalls.

module box_average_image_pyramid #(
	parameter int LEVELS    = bapyr_pkg::DEF_LEVELS,
	parameter int MAX_WIDTH = bapyr_pkg::DEF_MAX_WIDTH,
	parameter int FRAC_BITS = bapyr_pkg::DEF_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// pixel_value[7:0]
	input  logic [bapyr_pkg::TDATA_IN_W-1:0]     s_tdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// level_index[1:0], column[11:2], row[23:12], level_pixel[37:24], zero[39:38]
	output logic [bapyr_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_we,
	input  logic [bapyr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bapyr_pkg::CFG_W-1:0]          cfg_data
);

	localparam int VAL_W  = bapyr_pkg::PIX_W + FRAC_BITS;
	localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
	localparam int NREQ_W = $clog2(LEVELS + 1);

	logic [bapyr_pkg::WREG_W-1:0] width_q;
	logic [bapyr_pkg::HREG_W-1:0] height_q;
	logic [bapyr_pkg::NREG_W-1:0] count_q;

	logic [WEFF_W-1:0]           width_eff;
	logic [bapyr_pkg::HGT_W-1:0] height_eff;
	logic [NREQ_W-1:0]           nreq;
	logic [LEVELS-1:0]           next_on;

	bapyr_pkg::link_t                link_c [LEVELS+1];
	logic [VAL_W-1:0]                val_c  [LEVELS+1];
	bapyr_pkg::result_t [LEVELS-1:0] res_c  [LEVELS+1];
	logic [LEVELS:0]                 rdy_c;

	// configuration registers; any write restarts the frame in every cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bapyr_pkg::RST_IMAGE_WIDTH;
			height_q <= bapyr_pkg::RST_IMAGE_HEIGHT;
			count_q  <= bapyr_pkg::RST_LEVEL_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				bapyr_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[bapyr_pkg::WREG_W-1:0];
				end
				bapyr_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[bapyr_pkg::HREG_W-1:0];
				end
				bapyr_pkg::REG_LEVEL_COUNT: begin
					count_q <= cfg_data[bapyr_pkg::NREG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp the registers: zero counts as one, saturate at the limits
	always_comb begin
		if (width_q == '0) begin
			width_eff = WEFF_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_eff = WEFF_W'(MAX_WIDTH);
		end else begin
			width_eff = WEFF_W'(width_q);
		end

		if (height_q == '0) begin
			height_eff = bapyr_pkg::HGT_W'(1);
		end else if (32'(height_q) > bapyr_pkg::MAX_HEIGHT) begin
			height_eff = bapyr_pkg::HGT_W'(bapyr_pkg::MAX_HEIGHT);
		end else begin
			height_eff = height_q;
		end

		if (count_q == '0) begin
			nreq = NREQ_W'(1);
		end else if (32'(count_q) > LEVELS) begin
			nreq = NREQ_W'(LEVELS);
		end else begin
			nreq = NREQ_W'(count_q);
		end
	end

	// feed the full-size level straight from the input stream
	assign link_c[0] = '{valid: s_tvalid, go: 1'b1, frame_end: 1'b0};
	assign val_c[0]  = VAL_W'(s_tdata[bapyr_pkg::PIX_W-1:0]) << FRAC_BITS;
	assign res_c[0]  = '0;
	assign s_tready  = rdy_c[0];

	for (genvar g = 0; g < LEVELS; g++) begin : g_cell
		// level g+1 exists when requested and both dimensions stay at least one
		assign next_on[g] = ((g + 1) < int'(nreq)) &&
			((width_eff >> (g + 1)) != '0) && ((height_eff >> (g + 1)) != '0);

		bapyr_cell #(
			.LEVEL     (g),
			.LEVELS    (LEVELS),
			.MAX_WIDTH (MAX_WIDTH),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.restart    (cfg_we),
			.width_eff  (width_eff),
			.height_eff (height_eff),
			.next_on    (next_on[g]),
			.link_in    (link_c[g]),
			.v_in       (val_c[g]),
			.res_in     (res_c[g]),
			.in_ready   (rdy_c[g]),
			.link_s1    (link_c[g+1]),
			.v_out      (val_c[g+1]),
			.res_s1     (res_c[g+1]),
			.out_ready  (rdy_c[g+1])
		);
	end

	// unroll each finished run onto the result stream
	bapyr_serial #(
		.LEVELS (LEVELS)
	) u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (link_c[LEVELS].valid),
		.in_ready (rdy_c[LEVELS]),
		.res_in   (res_c[LEVELS]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[src/bapyr_cell.sv]
// One pyramid level: position counters, held left pixel and pair-sum line.
// Depends on bapyr_pkg.
`timescale 1ns / 1ps

module bapyr_cell #(
	parameter int LEVEL     = 0,
	parameter int LEVELS    = bapyr_pkg::DEF_LEVELS,
	parameter int MAX_WIDTH = bapyr_pkg::DEF_MAX_WIDTH,
	parameter int FRAC_BITS = bapyr_pkg::DEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
	input  logic [bapyr_pkg::HGT_W-1:0]        height_eff,
	input  logic                               next_on,
	input  bapyr_pkg::link_t                   link_in,
	input  logic [bapyr_pkg::PIX_W+FRAC_BITS-1:0] v_in,
	input  bapyr_pkg::result_t [LEVELS-1:0]    res_in,
	output logic                               in_ready,
	output bapyr_pkg::link_t                   link_s1,
	output logic [bapyr_pkg::PIX_W+FRAC_BITS-1:0] v_out,
	output bapyr_pkg::result_t [LEVELS-1:0]    res_s1,
	input  logic                               out_ready
);

	localparam int VAL_W    = bapyr_pkg::PIX_W + FRAC_BITS;
	localparam int PAIR_W   = VAL_W + 1;
	localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = bapyr_pkg::ROW_W;
	localparam int LINE_RAW = MAX_WIDTH >> (LEVEL + 1);
	localparam int LINE_D   = (LINE_RAW < 2) ? 2 : LINE_RAW;
	localparam int AW       = $clog2(LINE_D);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [VAL_W-1:0]  held_q;
	logic [PAIR_W-1:0] line_mem [LINE_D];
	logic [PAIR_W-1:0] pair_s1;
	logic [PAIR_W-1:0] rd_s1;

	logic              load;
	logic [WEFF_W-1:0] x_inc;
	logic [ROW_W-1:0]  y_inc;
	logic              col_wrap;
	logic              x_odd;
	logic              y_odd;
	logic              col_in;
	logic              row_in;
	logic              frame_end;
	logic              cont;
	logic              line_wr;
	logic [AW-1:0]     addr;
	logic [PAIR_W-1:0] pair;
	logic [PAIR_W:0]   quad;
	bapyr_pkg::result_t [LEVELS-1:0] res_next;

	assign in_ready = !link_s1.valid || out_ready;
	assign load     = link_in.valid && in_ready;

	assign x_inc    = WEFF_W'(col_q) + WEFF_W'(1);
	assign y_inc    = row_q + ROW_W'(1);
	assign col_wrap = x_inc >= (width_eff >> LEVEL);
	assign x_odd    = col_q[0];
	assign y_odd    = row_q[0];
	// block fits inside the next level
	assign col_in   = (WEFF_W'(col_q) >> 1) < (width_eff >> (LEVEL + 1));
	assign row_in   = (row_q >> 1) < ROW_W'(height_eff >> (LEVEL + 1));
	assign addr     = AW'(col_q >> 1);
	assign pair     = {1'b0, held_q} + {1'b0, v_in};

	// only the full-size level detects the end of the frame; the others get it through the link
	assign frame_end = link_in.frame_end ||
		((LEVEL == 0) && link_in.go && col_wrap && (y_inc >= ROW_W'(height_eff)));

	assign line_wr = load && link_in.go && next_on && x_odd && col_in && !y_odd;
	assign cont    = link_in.go && next_on && x_odd && col_in && y_odd && row_in;

	// mean of the 2x2 block for the next level
	assign quad  = {1'b0, rd_s1} + {1'b0, pair_s1};
	assign v_out = quad[PAIR_W:2];

	always_comb begin
		res_next = res_in;
		if (link_in.go) begin
			res_next[LEVEL].vld = 1'b1;
			res_next[LEVEL].lev = bapyr_pkg::LEV_OUT_W'(LEVEL);
			res_next[LEVEL].col = bapyr_pkg::COL_OUT_W'(col_q);
			res_next[LEVEL].row = bapyr_pkg::ROW_OUT_W'(row_q);
			res_next[LEVEL].pix = bapyr_pkg::PIX_OUT_W'(v_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (link_in.go) begin
				col_q <= col_wrap ? '0 : COL_W'(x_inc);
				row_q <= col_wrap ? y_inc : row_q;
			end
			if (link_in.go && next_on && !x_odd) begin
				held_q <= v_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
		end else if (load) begin
			link_s1.valid     <= 1'b1;
			link_s1.go        <= cont;
			link_s1.frame_end <= frame_end;
		end else if (out_ready) begin
			link_s1.valid <= 1'b0;
		end
	end

	// line memory and payload: no reset
	always_ff @(posedge clk) begin
		if (line_wr) begin
			line_mem[addr] <= pair;
		end
		if (load) begin
			rd_s1   <= line_mem[addr];
			pair_s1 <= pair;
			res_s1  <= res_next;
		end
	end

endmodule

[src/bapyr_serial.sv]
// Output stage: holds one run of results and shifts them out one per cycle while m_tready is high.
// Depends on bapyr_pkg.
`timescale 1ns / 1ps

module bapyr_serial #(
	parameter int LEVELS = bapyr_pkg::DEF_LEVELS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bapyr_pkg::result_t [LEVELS-1:0]      res_in,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bapyr_pkg::TDATA_OUT_W-1:0]    m_tdata,
	output logic                                 m_tlast
);

	localparam int FIELD_W = bapyr_pkg::LEV_OUT_W + bapyr_pkg::COL_OUT_W +
		bapyr_pkg::ROW_OUT_W + bapyr_pkg::PIX_OUT_W;

	logic [LEVELS-1:0]               vld_q;
	bapyr_pkg::result_t [LEVELS-1:0] slot_q;
	logic [LEVELS:0]                 vld_ext;
	bapyr_pkg::result_t [LEVELS:0]   slot_ext;
	logic [LEVELS-1:0]               vld_load;

	assign vld_ext  = {1'b0, vld_q};
	assign slot_ext = {bapyr_pkg::result_t'('0), slot_q};

	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			vld_load[i] = res_in[i].vld;
		end
	end

	assign m_tvalid = vld_q[0];
	assign m_tlast  = !vld_ext[1];
	assign in_ready = !vld_q[0] || (m_tready && m_tlast);
	assign m_tdata  = {(bapyr_pkg::TDATA_OUT_W - FIELD_W)'(0), slot_q[0].pix,
		slot_q[0].row, slot_q[0].col, slot_q[0].lev};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (in_valid && in_ready) begin
			vld_q <= vld_load;
		end else if (m_tvalid && m_tready) begin
			vld_q <= vld_ext[LEVELS:1];
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			slot_q <= res_in;
		end else if (m_tvalid && m_tready) begin
			slot_q <= slot_ext[LEVELS:1];
		end
	end

endmodule

[src/bapyr_checker.sv]
// Port-level checks for the box-average image pyramid, bound to the top level.
// Depends on bapyr_pkg and box_average_image_pyramid.
`timescale 1ns / 1ps

module bapyr_checker #(
	parameter int LEVELS    = bapyr_pkg::DEF_LEVELS,
	parameter int FRAC_BITS = bapyr_pkg::DEF_FRAC_BITS
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [bapyr_pkg::TDATA_OUT_W-1:0] m_tdata,
	input logic                              m_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready
);

	localparam logic [bapyr_pkg::PIX_OUT_W-1:0] FRAC_MASK =
		bapyr_pkg::PIX_OUT_W'((1 << FRAC_BITS) - 1);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// a run continues on the next level in the very next cycle
	a_run_next_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tvalid && (m_tdata[1:0] == 2'($past(m_tdata[1:0]) + 2'd1)))
		else $error("run broken or level out of sequence");

	// full-size pixels carry no fraction
	a_level0_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (LEVELS <= 4) && (m_tdata[1:0] == 2'd0) |->
		((m_tdata[37:24] & FRAC_MASK) == '0))
		else $error("level 0 pixel has fraction bits");

	// input ready is never unknown when an input is accepted
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !$isunknown(s_tready))
		else $error("input ready unknown at accept");

endmodule

bind box_average_image_pyramid bapyr_checker #(
	.LEVELS    (LEVELS),
	.FRAC_BITS (FRAC_BITS)
) u_bapyr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
